/* src/bfdh_pkg.sv */
// Package: shared constants and helper types for the bloom filter core
`timescale 1ns / 1ps
package bfdh_pkg;
  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] HASH_SEED = 64'h00000000a5a5a5a5;
  localparam logic [63:0] VALUE_LEN = 64'd32;
  localparam logic [63:0] ADD_A = 64'h0000000052dce729;
  localparam logic [63:0] ADD_B = 64'h0000000038495ab5;
  localparam logic [0:0] CMD_INSERT = 1'b0;
  localparam logic [0:0] CMD_QUERY = 1'b1;
  localparam logic [0:0] CFG_HASH_COUNT = 1'b0;
  localparam logic [0:0] CFG_BIT_COUNT = 1'b1;
  localparam logic [7:0] HASH_COUNT_RESET = 8'd40;
  localparam logic [16:0] BIT_COUNT_RESET = 17'd65536;

  typedef struct packed {
    logic start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
    rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
  endfunction
endpackage

/* src/bfdh_mul.sv */
// Module: iterative 64x64 low-word multiplier, 16 bits of operand b per cycle
`timescale 1ns / 1ps
module bfdh_mul
  import bfdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mul_req_t    req,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] acc;
  logic [63:0] a;
  logic [63:0] b;
  logic [1:0]  step;
  logic        busy;
  logic [79:0] part;

  assign part = {16'd0, a} * {64'd0, b[15:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
        acc <= 64'd0;
        a <= req.a;
        b <= req.b;
      end else if (busy) begin
        acc <= acc + part[63:0];
        a <= a << 16;
        b <= b >> 16;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule

/* src/bfdh_mod.sv */
// Module: restoring 64-bit by MW-bit remainder unit (MW is 25 by default), one bit per cycle
`timescale 1ns / 1ps
module bfdh_mod #(
  parameter int MW = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   dividend,
  input  logic [MW-1:0] divisor,
  output logic          done,
  output logic [MW-1:0] rem
);
  logic [63:0]   num;
  logic [MW:0]   r;
  logic [6:0]    cnt;
  logic          busy;
  logic [MW:0]   sh;

  assign sh = {r[MW-1:0], num[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num <= dividend;
        r <= '0;
        cnt <= 7'd0;
      end else if (busy) begin
        num <= num << 1;
        if (sh >= {1'b0, divisor}) r <= sh - {1'b0, divisor};
        else r <= sh;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r[MW-1:0];
endmodule

/* src/bloom_filter_double_hash_core.sv */
// Top level: bloom filter with MurmurHash3 x64 128 and double hashing
// Hashing runs on the multiplier that is shared with the probes (12 multiplies and 14
// ALU steps); each probe then does a multiply and add, a remainder and a table access.
// The core takes no new item until the last one is done (in_stall is high outside idle);
// a query stops at the first clear bit. Reset restores the register defaults and runs
// a clearing pass over the table rows before the first item.
`timescale 1ns / 1ps
module bloom_filter_double_hash_core
  import bfdh_pkg::*;
#(
  parameter int TABLE_BITS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [63:0] value_word0,
  input  logic [63:0] value_word1,
  input  logic [63:0] value_word2,
  input  logic [63:0] value_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        present
);
  localparam int ROWS = (TABLE_BITS + 63) / 64;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MW = $clog2(TABLE_BITS + 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_WAITM = 4'd3;
  localparam logic [3:0] S_PMUL  = 4'd4;
  localparam logic [3:0] S_PMODW = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_PMOD  = 4'd10;

  logic [3:0]  state;
  logic [7:0]  hash_count;
  logic [16:0] bit_count;
  logic        query;
  logic [63:0] w1, w2, w3;
  logic [63:0] ha, hb, k;
  logic [4:0]  op;
  logic [7:0]  probe;
  logic [63:0] h2;
  logic [MW-1:0] modulus;
  logic [RW-1:0] clr;
  logic        all_set;

  logic [63:0] mem [ROWS];
  logic [63:0] rdata;
  logic [RW-1:0] addr;
  logic [5:0]  bitsel;
  logic        we;
  logic [63:0] wdata;

  mul_req_t    mreq;
  logic        mdone;
  logic [63:0] mprod;
  logic        dstart;
  logic        ddone;
  logic [MW-1:0] drem;

  bfdh_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .prod(mprod));
  bfdh_mod #(.MW(MW)) u_mod (.clk(clk), .rst(rst), .start(dstart), .dividend(k),
    .divisor(modulus), .done(ddone), .rem(drem));

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  always_comb begin
    if ({15'd0, bit_count} == 32'd0 || {15'd0, bit_count} > TABLE_BITS)
      modulus = MW'(TABLE_BITS);
    else
      modulus = MW'(bit_count);
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // Hash micro-ops: each op is either a multiply (issued then waited) or simple ALU step.
  // op sequence per block: k1*C1, rot31, *C2, mix a ; k2*C2, rot33, *C1, mix b ; ...
  logic        op_mul;
  logic [63:0] mul_b;
  always_comb begin
    op_mul = 1'b0;
    mul_b = MM_C1;
    case (op)
      5'd0, 5'd8:  begin op_mul = 1'b1; mul_b = MM_C1; end
      5'd2, 5'd10: begin op_mul = 1'b1; mul_b = MM_C2; end
      5'd4, 5'd12: begin op_mul = 1'b1; mul_b = MM_C2; end
      5'd6, 5'd14: begin op_mul = 1'b1; mul_b = MM_C1; end
      5'd18, 5'd22: begin op_mul = 1'b1; mul_b = FMIX_C1; end
      5'd20, 5'd24: begin op_mul = 1'b1; mul_b = FMIX_C2; end
      default: ;
    endcase
  end

  always_comb begin
    mreq = '0;
    dstart = 1'b0;
    we = 1'b0;
    wdata = rdata | (64'd1 << bitsel);
    addr = clr;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wdata = 64'd0;
    end else begin
      addr = RW'(drem >> 6);
      if (state == S_UPD && !query) we = 1'b1;
    end
    if (state == S_HASH && op_mul) begin
      mreq.start = 1'b1;
      mreq.a = k;
      mreq.b = mul_b;
    end
    if (state == S_PMUL) begin
      mreq.start = 1'b1;
      mreq.a = {56'd0, probe};
      mreq.b = h2;
    end
    if (state == S_PMOD) dstart = 1'b1;
  end
  assign bitsel = drem[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      hash_count <= HASH_COUNT_RESET;
      bit_count <= BIT_COUNT_RESET;
      op <= 5'd0;
      probe <= 8'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HASH_COUNT) hash_count <= cfg_data[7:0];
        else bit_count <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + RW'(1);
          if (clr == RW'(ROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          query <= cmd;
          w1 <= value_word1;
          w2 <= value_word2; w3 <= value_word3;
          ha <= HASH_SEED; hb <= HASH_SEED;
          k <= value_word0;
          op <= 5'd0;
          state <= S_HASH;
        end
        S_HASH: begin
          if (op_mul) state <= S_WAITM;
          else begin
            op <= op + 5'd1;
            case (op)
              5'd1: k <= rotl(k, 6'd31);
              5'd9: begin
                k <= rotl(k, 6'd31);
                hb <= (hb << 2) + hb + ADD_B;
              end
              5'd3: begin ha <= rotl(ha ^ k, 6'd27) + hb; k <= w1; end
              5'd11: begin ha <= rotl(ha ^ k, 6'd27) + hb; k <= w3; end
              5'd5, 5'd13: begin
                k <= rotl(k, 6'd33);
                ha <= (ha << 2) + ha + ADD_A;
              end
              5'd7: begin
                hb <= rotl(hb ^ k, 6'd31) + ha;
                k <= w2;
              end
              5'd15: hb <= rotl(hb ^ k, 6'd31) + ha;
              5'd16: begin
                hb <= (hb << 2) + hb + ADD_B;
              end
              5'd17: begin
                ha <= (ha ^ VALUE_LEN) + (hb ^ VALUE_LEN);
                hb <= (hb ^ VALUE_LEN) + (ha ^ VALUE_LEN) + (hb ^ VALUE_LEN);
                k <= ((ha ^ VALUE_LEN) + (hb ^ VALUE_LEN)) ^
                     (((ha ^ VALUE_LEN) + (hb ^ VALUE_LEN)) >> 33);
              end
              5'd19, 5'd23: k <= k ^ (k >> 33);
              5'd21: begin
                ha <= k ^ (k >> 33);
                k <= hb ^ (hb >> 33);
              end
              5'd25: begin
                ha <= ha + (k ^ (k >> 33));
                h2 <= (ha + (k ^ (k >> 33)) + (k ^ (k >> 33))) | 64'd1;
                probe <= 8'd0;
                all_set <= 1'b1;
                state <= (hash_count == 8'd0) ? (query ? S_OUT : S_IDLE) : S_PMUL;
              end
              default: ;
            endcase
          end
        end
        S_WAITM: if (mdone) begin
          k <= mprod;
          op <= op + 5'd1;
          state <= S_HASH;
        end
        S_PMUL: state <= S_PMODW;
        S_PMODW: if (mdone) begin
          k <= ha + mprod;
          state <= S_PMOD;
        end
        S_PMOD: state <= S_RD;
        S_RD: if (ddone) state <= S_RDW;
        S_RDW: state <= S_UPD;
        S_UPD: begin
          if (query && !rdata[bitsel]) begin
            all_set <= 1'b0;
            state <= S_OUT;
          end else if (probe + 8'd1 == hash_count) begin
            state <= query ? S_OUT : S_IDLE;
          end else begin
            probe <= probe + 8'd1;
            state <= S_PMUL;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign present = all_set;

  a_out_query: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> query) else $error("result without query");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(present)))
    else $error("result dropped");
endmodule

/* tb/testbench.sv */
// Testbench for the double-hashing bloom filter core, checked against its own predictor
`timescale 1ns / 1ps
module testbench
  import bfdh_pkg::*;
();

  localparam int TBL_BITS = 65536;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int LONG_HOLD = 30000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [0:0]  idx;
    logic [16:0] data;
    logic        op;
    logic [63:0] w0, w1, w2, w3;
    bit          known;
    bit          exp_present;
  } stim_row_t;

  typedef struct {
    logic [63:0] w0, w1, w2, w3;
  } value_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_HASH_COUNT;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd = CMD_INSERT;
  logic [63:0] value_word0 = '0;
  logic [63:0] value_word1 = '0;
  logic [63:0] value_word2 = '0;
  logic [63:0] value_word3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        present;

  bit          member_bits [TBL_BITS];
  logic [7:0]  probe_count;
  logic [16:0] table_size;
  bit          present_q [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          hold_off_req = 1'b0;
  value_t      inserted_pool [$];
  stim_row_t   dir_rows [$];

  bloom_filter_double_hash_core #(.TABLE_BITS(TBL_BITS)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .value_word0(value_word0), .value_word1(value_word1),
    .value_word2(value_word2), .value_word3(value_word3),
    .out_valid(out_valid), .out_stall(out_stall), .present(present)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rot64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] avalanche(input logic [63:0] k);
    k = k ^ (k >> 33);
    k = k * FMIX_C1;
    k = k ^ (k >> 33);
    k = k * FMIX_C2;
    k = k ^ (k >> 33);
    return k;
  endfunction

  // MurmurHash3 x64 128 over two 16-byte blocks
  function automatic void hash_value(input value_t v, output logic [63:0] h1,
                                     output logic [63:0] h2);
    logic [63:0] a, b, k1, k2;
    logic [63:0] w [4];
    w[0] = v.w0; w[1] = v.w1; w[2] = v.w2; w[3] = v.w3;
    a = HASH_SEED;
    b = HASH_SEED;
    for (int blk = 0; blk < 2; blk++) begin
      k1 = w[2 * blk] * MM_C1;
      k1 = rot64(k1, 31) * MM_C2;
      a = rot64(a ^ k1, 27) + b;
      a = a * 64'd5 + ADD_A;
      k2 = w[2 * blk + 1] * MM_C2;
      k2 = rot64(k2, 33) * MM_C1;
      b = rot64(b ^ k2, 31) + a;
      b = b * 64'd5 + ADD_B;
    end
    a = a ^ VALUE_LEN;
    b = b ^ VALUE_LEN;
    a = a + b;
    b = b + a;
    a = avalanche(a);
    b = avalanche(b);
    a = a + b;
    b = b + a;
    h1 = a;
    h2 = b;
  endfunction

  // Apply one transaction to the shadow table; return whether a query answers
  function automatic bit probe_filter(input logic op, input value_t v);
    logic [63:0] h1, h2, modulus, pos;
    bit all_set;
    all_set = 1'b1;
    hash_value(v, h1, h2);
    h2[0] = 1'b1;
    modulus = (table_size == 0 || table_size > TBL_BITS) ? 64'(TBL_BITS) : 64'(table_size);
    for (int i = 0; i < probe_count; i++) begin
      pos = (h1 + 64'(i) * h2) % modulus;
      if (op == CMD_QUERY) begin
        if (!member_bits[pos]) begin
          all_set = 1'b0;
          break;
        end
      end else begin
        member_bits[pos] = 1'b1;
      end
    end
    return all_set;
  endfunction

  function automatic logic [63:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic value_t rand_value();
    value_t v;
    v.w0 = rand_word(); v.w1 = rand_word(); v.w2 = rand_word(); v.w3 = rand_word();
    return v;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 5);
    return $urandom_range(50, 600);
  endfunction

  task automatic add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (present_q.size() != 0) @(posedge clk);
    repeat (100 + 80 * int'(probe_count)) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [16:0] data);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HASH_COUNT) probe_count = data[7:0];
    else table_size = data;
  endtask

  // Offer one transaction and hold it until accepted, then record the expectation for a query
  task automatic send_item(input logic op, input value_t v, input bit known,
                           input bit exp_present);
    bit ans;
    cmd <= op;
    value_word0 <= v.w0; value_word1 <= v.w1;
    value_word2 <= v.w2; value_word3 <= v.w3;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ans = probe_filter(op, v);
    if (op == CMD_QUERY) begin
      if (known && ans != exp_present) begin
        $error("table entry disagrees with predictor: present exp %0d got %0d",
               exp_present, ans);
        error_count++;
      end
      present_q.insert(present_q.size(), known ? exp_present : ans);
    end
  endtask

  task automatic gap_after();
    int g;
    g = rand_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic stim_row_t cfg_row(input logic [0:0] idx, input logic [16:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: data, op: CMD_INSERT, w0: 0, w1: 0, w2: 0,
          w3: 0, known: 0, exp_present: 0};
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic op, input logic [63:0] w,
                                         input bit known, input bit exp_present);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: CFG_HASH_COUNT, data: '0, op: op, w0: w, w1: ~w,
          w2: {w[31:0], w[63:32]}, w3: w, known: known, exp_present: exp_present};
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (present_q.size() == 0) begin
        $error("unexpected result: present got %0d", present);
        error_count++;
      end else begin
        if (present !== present_q[0]) begin
          $error("mismatch on present: expected %0d actual %0d", present_q[0], present);
          error_count++;
        end
        present_q.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 9);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end else if (r < 5) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 30);
        repeat (n) @(posedge clk);
      end else if (r < 9) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(50, 400);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    value_t v;
    int r;
    probe_count = HASH_COUNT_RESET;
    table_size = BIT_COUNT_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_row(item_row(CMD_QUERY, 64'h0, 1, 0));
    add_row(item_row(CMD_QUERY, '1, 1, 0));
    add_row(item_row(CMD_INSERT, 64'h0, 0, 0));
    add_row(item_row(CMD_QUERY, 64'h0, 1, 1));
    add_row(item_row(CMD_INSERT, '1, 0, 0));
    add_row(item_row(CMD_QUERY, '1, 1, 1));
    add_row(item_row(CMD_QUERY, 64'h8000000000000001, 0, 0));
    add_row(item_row(CMD_INSERT, 64'h5555555555555555, 0, 0));
    add_row(item_row(CMD_QUERY, 64'hAAAAAAAAAAAAAAAA, 0, 0));
    add_row(cfg_row(CFG_HASH_COUNT, 17'd0));
    add_row(item_row(CMD_QUERY, 64'h0123456789ABCDEF, 1, 1));
    add_row(item_row(CMD_INSERT, 64'hDEADBEEFCAFEF00D, 0, 0));
    add_row(cfg_row(CFG_BIT_COUNT, 17'd64));
    add_row(cfg_row(CFG_HASH_COUNT, 17'h1FFFF));
    add_row(item_row(CMD_INSERT, 64'hAAAAAAAAAAAAAAAA, 0, 0));
    add_row(item_row(CMD_QUERY, 64'h5555555555555555, 0, 0));
    add_row(cfg_row(CFG_BIT_COUNT, 17'd0));
    add_row(cfg_row(CFG_HASH_COUNT, 17'd1));
    add_row(item_row(CMD_QUERY, 64'h123456789ABCDEF0, 0, 0));
    add_row(cfg_row(CFG_BIT_COUNT, 17'h1FFFF));
    add_row(item_row(CMD_INSERT, 64'h0F0F0F0F0F0F0F0F, 0, 0));
    add_row(item_row(CMD_QUERY, 64'h0F0F0F0F0F0F0F0F, 1, 1));
    add_row(cfg_row(CFG_BIT_COUNT, 17'd100));
    add_row(item_row(CMD_INSERT, 64'hF0F0F0F0F0F0F0F0, 0, 0));
    add_row(item_row(CMD_QUERY, 64'hF0F0F0F0F0F0F0F0, 1, 1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        v = '{w0: dir_rows[i].w0, w1: dir_rows[i].w1, w2: dir_rows[i].w2,
              w3: dir_rows[i].w3};
        send_item(dir_rows[i].op, v, dir_rows[i].known, dir_rows[i].exp_present);
        gap_after();
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      r = $urandom_range(0, 2);
      write_reg(CFG_HASH_COUNT, (ph == 2) ? 17'd128 : 17'($urandom_range(1, 16)));
      if (r == 0) write_reg(CFG_BIT_COUNT, 17'(64 * $urandom_range(1, 16)));
      else if (r == 1) write_reg(CFG_BIT_COUNT, 17'(64 * $urandom_range(1, 1024)));
      else write_reg(CFG_BIT_COUNT, 17'($urandom_range(1, 131071)));
      inserted_pool.delete();
      for (int k = 0; k < 34; k++) begin
        if (ph == 0 && k == 4) hold_off_req = 1'b1;
        if (ph == 1 && k == 17) begin
          in_valid <= 1'b0;
          while (present_q.size() != 0) @(posedge clk);
        end
        r = $urandom_range(0, 9);
        if (r < 4 || inserted_pool.size() == 0) begin
          v = rand_value();
          inserted_pool.insert(inserted_pool.size(), v);
          send_item(CMD_INSERT, v, 0, 0);
        end else if (r < 8) begin
          v = inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
          send_item(CMD_QUERY, v, 0, 0);
        end else begin
          send_item(CMD_QUERY, rand_value(), 0, 0);
        end
        gap_after();
      end
    end

    drain_and_settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
